### hdl/chml_pkg.sv
// ----------------------------------------------------------------------------
// chml_pkg
// Shared types, constants and the header length decode for the command
// header match and length block.
// ----------------------------------------------------------------------------
package chml_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 9;

    localparam logic       KIND_LOAD   = 1'b0;
    localparam logic       KIND_DECODE = 1'b1;

    localparam logic [2:0] TYPE_MI     = 3'd0;
    localparam logic [2:0] TYPE_GFX    = 3'd3;
    localparam logic [1:0] SUB_SHORT   = 2'd1;
    localparam logic [1:0] SUB_PAIR    = 2'd2;
    localparam logic [5:0] MI_SHORT_LIM = 6'd16;

    typedef struct packed {
        logic        kind;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [31:0] entry_mask;
        logic [31:0] header_word;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] command_index;
        logic [8:0] length_dwords;
        logic       bad_type;
    } out_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] mask;
    } tbl_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        tbl_entry_t        data;
    } tbl_wr_t;

    typedef struct packed {
        logic       bad;
        logic [8:0] length;
    } len_t;

    function automatic len_t header_length(input logic [31:0] h);
        len_t r;
        r.bad    = 1'b0;
        r.length = 9'(h[7:0]) + 9'd2;
        if (h[31:29] == TYPE_MI) begin
            if (h[28:23] < MI_SHORT_LIM) begin
                r.length = 9'd1;
            end
        end else if (h[31:29] == TYPE_GFX) begin
            case (h[28:27])
                SUB_SHORT: r.length = 9'd1;
                SUB_PAIR:  r.length = 9'd2;
                default:   r.length = 9'(h[7:0]) + 9'd2;
            endcase
        end else begin
            r.bad    = 1'b1;
            r.length = 9'd0;
        end
        return r;
    endfunction

endpackage

### hdl/chml_table.sv
// ----------------------------------------------------------------------------
// chml_table
// Command table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chml_table (
    input  logic                       aclk,
    input  chml_pkg::tbl_wr_t          wr,
    input  logic [chml_pkg::ADDR_W-1:0] rd_addr,
    output chml_pkg::tbl_entry_t       rd_data
);

    chml_pkg::tbl_entry_t mem [chml_pkg::TABLE_DEPTH];
    chml_pkg::tbl_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/chml_seq.sv
// ----------------------------------------------------------------------------
// chml_seq
// Sequencer: takes items, writes table loads, scans the table one entry per
// cycle through a shared masked compare, and holds the result register.
// ----------------------------------------------------------------------------
module chml_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  chml_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output chml_pkg::out_item_t         m_data,
    input  logic [chml_pkg::CFG_W-1:0]  entry_count,
    output chml_pkg::tbl_wr_t           tbl_wr,
    output logic [chml_pkg::ADDR_W-1:0] rd_addr,
    input  chml_pkg::tbl_entry_t        rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [chml_pkg::CNT_W-1:0] addr_reg, addr_next;
    logic [chml_pkg::CNT_W-1:0] lim_reg, lim_next;
    logic [chml_pkg::CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [31:0]                header_reg, header_next;
    logic                       found_reg, found_next;
    logic [7:0]                 hit_reg, hit_next;
    logic                       m_valid_reg, m_valid_next;
    chml_pkg::out_item_t        m_data_reg, m_data_next;

    logic                       accept;
    logic                       hit;
    logic [chml_pkg::CNT_W-1:0] lim_in;
    chml_pkg::len_t             len;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign rd_addr = addr_reg[chml_pkg::ADDR_W-1:0];
    assign hit     = ((header_reg & rd_data.mask) == rd_data.value);
    assign len     = chml_pkg::header_length(header_reg);

    assign lim_in = (32'(entry_count) > 32'(chml_pkg::TABLE_DEPTH))
                  ? chml_pkg::CNT_W'(chml_pkg::TABLE_DEPTH)
                  : chml_pkg::CNT_W'(entry_count);

    always_comb begin
        tbl_wr.en   = accept && (s_data.kind == chml_pkg::KIND_LOAD)
                   && (32'(s_data.entry_index) < 32'(chml_pkg::TABLE_DEPTH));
        tbl_wr.addr = chml_pkg::ADDR_W'(s_data.entry_index);
        tbl_wr.data.value = s_data.entry_value;
        tbl_wr.data.mask  = s_data.entry_mask;
    end

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        lim_next     = lim_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        header_next  = header_reg;
        found_next   = found_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.kind == chml_pkg::KIND_DECODE)) begin
                    header_next = s_data.header_word;
                    lim_next    = lim_in;
                    addr_next   = '0;
                    found_next  = 1'b0;
                    hit_next    = 8'd0;
                    state_next  = (lim_in == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (addr_reg < lim_reg) begin
                    addr_next    = addr_reg + 1'b1;
                    cmp_idx_next = addr_reg;
                    cmp_vld_next = 1'b1;
                end
                if (cmp_vld_reg) begin
                    if (hit) begin
                        found_next   = 1'b1;
                        hit_next     = 8'(cmp_idx_reg);
                        cmp_vld_next = 1'b0;
                        state_next   = ST_DONE;
                    end else if (cmp_idx_reg == lim_reg - 1'b1) begin
                        cmp_vld_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.found         = found_reg;
                    m_data_next.command_index = hit_reg;
                    m_data_next.length_dwords = len.length;
                    m_data_next.bad_type      = len.bad;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        lim_reg     <= lim_next;
        cmp_idx_reg <= cmp_idx_next;
        header_reg  <= header_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        m_data_reg  <= m_data_next;
    end

endmodule

### hdl/command_header_match_and_length_top.sv
// ----------------------------------------------------------------------------
// command_header_match_and_length_top
// Command header matcher and length decoder.
//
// Input items (s_valid/s_ready/s_data) either load one table entry (match
// value and mask) or decode a header word. A load writes its entry into the
// table when accepted and returns nothing. A decode scans entries 0 ..
// min(entry_count, 256) - 1 in order and returns one item on
// m_valid/m_ready/m_data: first matching entry, found flag, command length
// in dwords and a bad type flag. The scan reads one table entry per cycle
// from the table memory and stops at the first match or after the last entry.
// The block accepts no new item during a scan. A finished result sits in the
// output register; new items are accepted while it waits to be taken. If the
// receiver stalls with a result still pending, the next decode holds at the
// end of its scan until the register frees.
// entry_count is written through cfg_valid/cfg_ready/cfg_data, always ready.
// Reset clears control state and entry_count; table contents stay undefined
// until loaded.
// ----------------------------------------------------------------------------
module command_header_match_and_length_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  chml_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output chml_pkg::out_item_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [chml_pkg::CFG_W-1:0] cfg_data
);

    logic [chml_pkg::CFG_W-1:0]  entry_count_reg, entry_count_next;
    chml_pkg::tbl_wr_t           tbl_wr;
    logic [chml_pkg::ADDR_W-1:0] rd_addr;
    chml_pkg::tbl_entry_t        rd_data;

    assign cfg_ready        = 1'b1;
    assign entry_count_next = (cfg_valid && cfg_ready) ? cfg_data : entry_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else begin
            entry_count_reg <= entry_count_next;
        end
    end

    chml_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    chml_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .entry_count (entry_count_reg),
        .tbl_wr      (tbl_wr),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

endmodule

### hdl/chml_checker.sv
// ----------------------------------------------------------------------------
// chml_checker
// Port-level checks for the command header matcher, bound to the top level.
// ----------------------------------------------------------------------------
module chml_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input chml_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_bad_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_type |-> m_data.length_dwords == 9'd0)
        else $error("bad type with nonzero length");

    a_good_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bad_type |->
            m_data.length_dwords != 9'd0 && m_data.length_dwords <= 9'd257)
        else $error("length out of range");

    a_miss_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.command_index == 8'd0)
        else $error("index set without a match");

endmodule

bind command_header_match_and_length_top chml_checker u_chml_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
